>>> design/slsfp_pkg.sv
package slsfp_pkg;

    // Bytes a frame may reach before it is dropped as too long.
    localparam int FRAME_DEPTH = 10;

    // Sync, length and checksum overhead of a frame in bytes.
    localparam int HEADER_LEN  = 4;

    localparam int CNT_W       = 4;
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
    localparam logic [BYTE_W-1:0] FULL_BYTE   = 8'hFF;

    // Frame byte positions that carry meaning.
    localparam logic [CNT_W-1:0] POS_SYNC_FIRST  = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_SYNC_SECOND = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_LENGTH      = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_FOCUS       = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_ZOOM        = CNT_W'(4);

endpackage

>>> design/slsfp_stream_if.sv
interface slsfp_in_if;
    logic                            valid;
    logic                            ready;
    logic [slsfp_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slsfp_out_if;
    logic valid;
    logic ready;
    logic focus_hint;
    logic zoom_hint;
    logic frame_done;
    logic frame_good;

    modport source (output valid, output focus_hint, output zoom_hint,
                    output frame_done, output frame_good, input ready);
    modport sink   (input valid, input focus_hint, input zoom_hint,
                    input frame_done, input frame_good, output ready);
endinterface

>>> design/sync_length_sum_frame_parser.sv
// The result of an input transfer is loaded into the output register in the next cycle.
// Throughput: one byte per cycle while the output register is not stalled; the parser
// state and running sum update in one pass, and the output register takes a new result whenever it is empty or drained.
// Reset: i_rst_n is synchronous and active low; it clears the byte count, stored
// header flags, sum, good-frame mark, hints and the output valid.
module sync_length_sum_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slsfp_in_if.sink    i_in,
    slsfp_out_if.source o_out
);

    localparam int SUM_CMP_W = slsfp_pkg::BYTE_W + 1;

    // Parser state
    logic [slsfp_pkg::CNT_W-1:0]  r_byte_count, n_byte_count;
    logic [slsfp_pkg::BYTE_W-1:0] r_length_byte, n_length_byte;
    logic                         r_second_sync_ok, n_second_sync_ok;
    logic [slsfp_pkg::BYTE_W-1:0] r_running_sum, n_running_sum;
    logic                         r_good_mark, n_good_mark;
    logic                         r_third_full, n_third_full;
    logic                         r_fourth_full, n_fourth_full;
    logic [1:0]                   r_hint_bits, n_hint_bits;
    logic                         n_done;

    // Output register
    logic r_out_valid;
    logic r_focus_hint;
    logic r_zoom_hint;
    logic r_frame_done;
    logic r_frame_good;

    logic                         in_xfer;
    logic [slsfp_pkg::BYTE_W-1:0] b;
    logic [SUM_CMP_W-1:0]         count_ext;
    logic [SUM_CMP_W-1:0]         frame_end;
    logic [slsfp_pkg::CNT_W:0]    count;

    // Accept a byte whenever the output register is free or is draining this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign b          = i_in.rx_byte;

    assign count     = {1'b0, r_byte_count} + (slsfp_pkg::CNT_W+1)'(1);
    assign count_ext = SUM_CMP_W'(count);
    assign frame_end = {1'b0, r_length_byte} + SUM_CMP_W'(slsfp_pkg::HEADER_LEN);

    always_comb begin
        n_byte_count     = r_byte_count;
        n_length_byte    = r_length_byte;
        n_second_sync_ok = r_second_sync_ok;
        n_running_sum    = r_running_sum;
        n_good_mark      = r_good_mark;
        n_third_full     = r_third_full;
        n_fourth_full    = r_fourth_full;
        n_hint_bits      = r_hint_bits;
        n_done           = 1'b0;

        // Capture header bytes as they arrive, even if this byte ends in an error.
        case (r_byte_count)
            slsfp_pkg::POS_SYNC_SECOND: n_second_sync_ok = (b == slsfp_pkg::SYNC_SECOND);
            slsfp_pkg::POS_LENGTH:      n_length_byte    = b;
            slsfp_pkg::POS_FOCUS:       n_third_full     = (b == slsfp_pkg::FULL_BYTE);
            slsfp_pkg::POS_ZOOM:        n_fourth_full    = (b == slsfp_pkg::FULL_BYTE);
            default: ;
        endcase

        if (r_byte_count == slsfp_pkg::POS_SYNC_FIRST && b != slsfp_pkg::SYNC_FIRST) begin
            // Bad first sync: restart at once, hints hold.
            n_good_mark   = 1'b0;
            n_byte_count  = '0;
            n_running_sum = '0;
        end else if (count > (slsfp_pkg::CNT_W+1)'(3) && !n_second_sync_ok) begin
            // Bad second sync, seen once the header is in.
            n_good_mark   = 1'b0;
            n_byte_count  = '0;
            n_running_sum = '0;
        end else if (count > (slsfp_pkg::CNT_W+1)'(3) && count_ext >= frame_end) begin
            // Last byte is the checksum.
            n_good_mark   = (r_running_sum == b);
            n_done        = 1'b1;
            n_byte_count  = '0;
            n_running_sum = '0;
            if (n_good_mark) begin
                n_hint_bits = {n_fourth_full, n_third_full};
            end
        end else if (count >= (slsfp_pkg::CNT_W+1)'(slsfp_pkg::FRAME_DEPTH)) begin
            // Drop a frame that fills the buffer without ending.
            n_good_mark   = 1'b0;
            n_byte_count  = '0;
            n_running_sum = '0;
        end else begin
            n_running_sum = r_running_sum + b;
            n_byte_count  = count[slsfp_pkg::CNT_W-1:0];
            if (r_good_mark) begin
                n_hint_bits = {n_fourth_full, n_third_full};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count     <= '0;
            r_length_byte    <= '0;
            r_second_sync_ok <= 1'b0;
            r_running_sum    <= '0;
            r_good_mark      <= 1'b0;
            r_third_full     <= 1'b0;
            r_fourth_full    <= 1'b0;
            r_hint_bits      <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_byte_count     <= n_byte_count;
                r_length_byte    <= n_length_byte;
                r_second_sync_ok <= n_second_sync_ok;
                r_running_sum    <= n_running_sum;
                r_good_mark      <= n_good_mark;
                r_third_full     <= n_third_full;
                r_fourth_full    <= n_fourth_full;
                r_hint_bits      <= n_hint_bits;
                r_out_valid      <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load with each input transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_focus_hint <= n_hint_bits[0];
            r_zoom_hint  <= n_hint_bits[1];
            r_frame_done <= n_done;
            r_frame_good <= n_good_mark;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.focus_hint = r_focus_hint;
    assign o_out.zoom_hint  = r_zoom_hint;
    assign o_out.frame_done = r_frame_done;
    assign o_out.frame_good = r_frame_good;

endmodule
